@@ design/paf_pkg.sv @@
// shared types and constants for the posture alarm filter
// no dependencies
package paf_pkg;

  localparam int AngleW  = 12;
  localparam int LimitW  = 14;
  localparam int ThreshW = 8;
  localparam int HoldW   = 16;
  localparam int CoolW   = 20;
  localparam int ShiftW  = 3;
  localparam int TimeW   = 32;
  localparam int KpW     = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 20;
  localparam int InDatW  = 56;
  localparam int OutDatW = 16;

  localparam logic [KpW-1:0] KpAll = KpW'(3);
  localparam logic [3:0]     DegToTenths = 4'd10;

  localparam logic signed [AngleW-1:0] BaseReset   = '0;
  localparam logic [ThreshW-1:0]       ThreshReset = 8'd15;
  localparam logic [HoldW-1:0]         HoldReset   = 16'd1500;
  localparam logic [CoolW-1:0]         CoolReset   = 20'd10000;
  localparam logic [ShiftW-1:0]        ShiftReset  = 3'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE_ANGLE = 3'd0,
    CFG_THRESHOLD  = 3'd1,
    CFG_HOLD_TIME  = 3'd2,
    CFG_COOLDOWN   = 3'd3,
    CFG_SHIFT      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic           study_mode;
    logic           person_seen;
    logic           head_in_view;
    logic [KpW-1:0] keypoint_count;
  } frame_flags_t;

  typedef struct packed {
    logic signed [AngleW-1:0] base_angle;
    logic [ThreshW-1:0]       threshold_degrees;
    logic [HoldW-1:0]         hold_time_ms;
    logic [CoolW-1:0]         cooldown_ms;
  } alarm_cfg_t;

endpackage

@@ design/paf_filter.sv @@
// first-order low-pass on the pitch angle, loaded by the first item
// depends on paf_pkg
module paf_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic signed [paf_pkg::AngleW-1:0]   pitch,
  input  logic [paf_pkg::ShiftW-1:0]          shift,
  output logic signed [paf_pkg::AngleW-1:0]   smoothed
);
  import paf_pkg::*;

  logic signed [AngleW-1:0] filt_r;
  logic                     loaded_r;
  logic signed [AngleW:0]   diff;
  logic signed [AngleW+1:0] adj;
  logic signed [AngleW+1:0] step;
  logic signed [AngleW+1:0] bias;
  logic signed [AngleW+1:0] sum;

  always_comb begin
    diff = $signed({pitch[AngleW-1], pitch}) - $signed({filt_r[AngleW-1], filt_r});
    // round toward zero for negative differences
    bias = diff[AngleW] ? (AngleW+2)'((15'd1 << shift) - 15'd1) : '0;
    adj  = $signed({diff[AngleW], diff}) + bias;
    step = adj >>> shift;
    sum  = $signed({{2{filt_r[AngleW-1]}}, filt_r}) + step;
    smoothed = loaded_r ? sum[AngleW-1:0] : pitch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filt_r   <= '0;
      loaded_r <= 1'b0;
    end else if (en) begin
      filt_r   <= smoothed;
      loaded_r <= 1'b1;
    end
  end

endmodule

@@ design/paf_alarm.sv @@
// bad-frame test with hold and cooldown timing
// depends on paf_pkg
module paf_alarm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  paf_pkg::frame_flags_t              flags,
  input  logic signed [paf_pkg::AngleW-1:0]  smoothed,
  input  logic [paf_pkg::TimeW-1:0]          now_ms,
  input  paf_pkg::alarm_cfg_t                cfg,
  output logic                               trigger,
  output logic                               active
);
  import paf_pkg::*;

  logic [TimeW-1:0]         hold_start_r;
  logic [TimeW-1:0]         hold_start_nxt;
  logic [TimeW-1:0]         last_trig_r;
  logic [TimeW-1:0]         last_trig_nxt;
  logic signed [LimitW-1:0] limit;
  logic [ThreshW+3:0]       thr_tenths;
  logic [TimeW-1:0]         hs;
  logic [TimeW-1:0]         held;
  logic [TimeW-1:0]         since;

  always_comb begin
    thr_tenths = cfg.threshold_degrees * DegToTenths;
    limit = $signed({{(LimitW-AngleW){cfg.base_angle[AngleW-1]}}, cfg.base_angle})
            + $signed({{(LimitW-ThreshW-4){1'b0}}, thr_tenths});
    active = flags.study_mode && flags.person_seen && flags.head_in_view
             && (flags.keypoint_count >= KpAll)
             && ($signed({{(LimitW-AngleW){smoothed[AngleW-1]}}, smoothed}) > limit);
    hs      = (hold_start_r == '0) ? now_ms : hold_start_r;
    held    = now_ms - hs;
    since   = now_ms - last_trig_r;
    trigger = 1'b0;
    hold_start_nxt = '0;
    last_trig_nxt  = last_trig_r;
    if (active) begin
      hold_start_nxt = hs;
      if (held >= TimeW'(cfg.hold_time_ms) &&
          (last_trig_r == '0 || since >= TimeW'(cfg.cooldown_ms))) begin
        trigger        = 1'b1;
        last_trig_nxt  = now_ms;
        hold_start_nxt = now_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_start_r <= '0;
      last_trig_r  <= '0;
    end else if (en) begin
      hold_start_r <= hold_start_nxt;
      last_trig_r  <= last_trig_nxt;
    end
  end

endmodule

@@ design/posture_alarm_filter.sv @@
// posture alarm filter top level: config registers, input and result registers
// depends on paf_pkg, paf_filter, paf_alarm
//
// channel  direction  width  contents
// in_*     in         56     pitch, presence flags, keypoints, study mode, time
// out_*    out        16     trigger, active, smoothed angle
// cfg_*    in         20     register writes, no read-back
//
// one item per cycle while the output is not stalled; results are registered
// filter and alarm state update in the same cycle as the result is formed
// an input register and a result register part the two sides; a stalled
// result holds while one more item waits in the input register
// synchronous active-low reset restores register defaults and clears state
module posture_alarm_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // pitch_tenths[11:0] person_seen[12] head_in_view[13] keypoint_count[15:14]
  // study_mode[16] now_ms[48:17] zero[55:49]
  input  logic [paf_pkg::InDatW-1:0]    in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // alarm_trigger[0] alarm_active[1] smoothed_angle[13:2] zero[15:14]
  output logic [paf_pkg::OutDatW-1:0]   out_tdata,
  input  logic                          cfg_we,
  input  logic [paf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [paf_pkg::CfgDatW-1:0]   cfg_wdata
);
  import paf_pkg::*;

  alarm_cfg_t               acfg_r;
  logic [ShiftW-1:0]        shift_r;
  logic                     in_vld_r;
  logic [InDatW-1:0]        in_dat_r;
  logic                     out_vld_r;
  logic [OutDatW-1:0]       out_dat_r;
  logic                     adv;
  frame_flags_t             flags;
  logic signed [AngleW-1:0] smoothed;
  logic                     trigger;
  logic                     active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acfg_r.base_angle        <= BaseReset;
      acfg_r.threshold_degrees <= ThreshReset;
      acfg_r.hold_time_ms      <= HoldReset;
      acfg_r.cooldown_ms       <= CoolReset;
      shift_r                  <= ShiftReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE_ANGLE: acfg_r.base_angle        <= cfg_wdata[AngleW-1:0];
        CFG_THRESHOLD:  acfg_r.threshold_degrees <= cfg_wdata[ThreshW-1:0];
        CFG_HOLD_TIME:  acfg_r.hold_time_ms      <= cfg_wdata[HoldW-1:0];
        CFG_COOLDOWN:   acfg_r.cooldown_ms       <= cfg_wdata[CoolW-1:0];
        CFG_SHIFT:      shift_r                  <= cfg_wdata[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_dat_r <= in_tdata;
    end
  end

  assign flags.person_seen    = in_dat_r[12];
  assign flags.head_in_view   = in_dat_r[13];
  assign flags.keypoint_count = in_dat_r[15:14];
  assign flags.study_mode     = in_dat_r[16];

  paf_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .pitch    (in_dat_r[AngleW-1:0]),
    .shift    (shift_r),
    .smoothed (smoothed)
  );

  paf_alarm u_alarm (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .flags    (flags),
    .smoothed (smoothed),
    .now_ms   (in_dat_r[48:17]),
    .cfg      (acfg_r),
    .trigger  (trigger),
    .active   (active)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dat_r <= {2'b00, smoothed, active, trigger};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

endmodule
